/* rtl/core/diff_swerve_module_steer_drive_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the differential swerve steer and drive core
// Checks compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DIFF_SWERVE_MODULE_STEER_DRIVE_CORE_MACROS_SVH
`define DIFF_SWERVE_MODULE_STEER_DRIVE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// property checked at every clock edge outside reset
`define DSM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");
// implication checked outside reset
`define DSM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");
`else
`define DSM_ASSERT(lbl, clk, rst_n, prop)
`define DSM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/dsm_pkg.sv */
// ----------------------------------------------------------------------------
// dsm_pkg
// Shared widths, constants and helper functions of the swerve module core.
// ----------------------------------------------------------------------------
package dsm_pkg;

  // serial divider: dividend and divisor widths
  localparam int unsigned DIV_NW = 48;
  localparam int unsigned DIV_DW = 21;

  // cordic datapath widths
  localparam int unsigned CRD_W  = 44;
  localparam int unsigned CRD_ZW = 27;

  // setpoint search width
  localparam int unsigned POS_W = 40;

  // config register indexes
  typedef enum logic [1:0] {
    REG_MODULE_X   = 2'd0,
    REG_MODULE_Y   = 2'd1,
    REG_MAX_RADIUS = 2'd2,
    REG_DEAD_ZONE  = 2'd3
  } reg_idx_e;

  localparam logic signed [CRD_ZW-1:0] Z_HALF_TURN = 27'sd11796480;

  function automatic logic [21:0] atan_entry(input logic [4:0] i);
    logic [21:0] r;
    case (i)
      5'd0:    r = 22'd2949120;
      5'd1:    r = 22'd1740967;
      5'd2:    r = 22'd919879;
      5'd3:    r = 22'd466945;
      5'd4:    r = 22'd234378;
      5'd5:    r = 22'd117304;
      5'd6:    r = 22'd58666;
      5'd7:    r = 22'd29335;
      5'd8:    r = 22'd14668;
      5'd9:    r = 22'd7334;
      5'd10:   r = 22'd3667;
      5'd11:   r = 22'd1833;
      5'd12:   r = 22'd917;
      5'd13:   r = 22'd458;
      5'd14:   r = 22'd229;
      5'd15:   r = 22'd115;
      5'd16:   r = 22'd57;
      5'd17:   r = 22'd29;
      5'd18:   r = 22'd14;
      5'd19:   r = 22'd7;
      5'd20:   r = 22'd4;
      5'd21:   r = 22'd2;
      5'd22:   r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

  // offset of each setpoint option from the base, 1/16 degree
  function automatic logic signed [14:0] opt_off(input logic [2:0] i);
    logic signed [14:0] r;
    case (i)
      3'd0:    r = -15'sd5760;
      3'd1:    r = -15'sd2880;
      3'd2:    r = 15'sd0;
      3'd3:    r = 15'sd2880;
      3'd4:    r = 15'sd5760;
      3'd5:    r = 15'sd8640;
      default: r = 15'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [16:0] sat17(input logic signed [43:0] v);
    logic signed [16:0] r;
    if (v > 44'sd65535) begin
      r = 17'sd65535;
    end else if (v < -44'sd65536) begin
      r = -17'sd65536;
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

  function automatic logic signed [27:0] sat28(input logic signed [POS_W-1:0] v);
    logic signed [27:0] r;
    if (v > 40'sd134217727) begin
      r = 28'sd134217727;
    end else if (v < -40'sd134217728) begin
      r = -28'sd134217728;
    end else begin
      r = v[27:0];
    end
    return r;
  endfunction

  function automatic logic in_dead(input logic signed [15:0] v, input logic [14:0] dz);
    logic [16:0] a;
    a = v[15] ? 17'(-(17'(v))) : 17'(v);
    return a <= 17'(dz);
  endfunction

endpackage

/* rtl/core/diff_swerve_module_steer_drive_core.sv */
// ----------------------------------------------------------------------------
// diff_swerve_module_steer_drive_core
// Steering setpoint and motor power mixing of one differential swerve module.
// One item at a time: a steer item runs four divisions on the shared
// bit-serial divider plus CORDIC_STEPS cordic iterations and a setpoint
// search over six options (a zero vector skips the cordic); a drive item runs
// one division, or none when the steering error is under one degree.
// The result is held in an output register until taken; no new item is
// accepted meanwhile.
// ----------------------------------------------------------------------------
module diff_swerve_module_steer_drive_core #(
  parameter int unsigned COUNTS_PER_TURN = 360,
  parameter int unsigned CORDIC_STEPS    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  // input items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic signed [15:0] stick_x_i,
  input  logic signed [15:0] stick_y_i,
  input  logic signed [15:0] stick_twist_i,
  input  logic               operator_mode_i,
  input  logic signed [15:0] drive_speed_i,
  input  logic signed [27:0] heading_position_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [16:0] module_power_o,
  output logic signed [27:0] steer_target_o,
  output logic               wheel_reversed_o,
  output logic signed [16:0] master_power_o,
  output logic signed [16:0] slave_power_o
);
  import dsm_pkg::*;

  localparam logic [DIV_DW-1:0] DEN_TURNS = DIV_DW'(16 * COUNTS_PER_TURN);
  localparam logic [DIV_DW-1:0] DEN_CUR   = DIV_DW'(COUNTS_PER_TURN);
  localparam logic [DIV_DW-1:0] DEN_ERR   = 21'd2880;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV_B, ST_DIV_C, ST_CORDIC, ST_DIV_T, ST_DIV_P,
    ST_PICK, ST_SET, ST_DRV_DIV, ST_MIX, ST_OUT
  } state_e;

  state_e state_q;

  logic signed [15:0] mx_q, my_q;
  logic [14:0]        rad_q, dz_q;
  logic signed [15:0] sx_q, sy_q, tw_q, spd_q, prev_q;
  logic               op_q, act_q;
  logic signed [27:0] head_q;
  logic signed [31:0] bp_q, cp_q;
  logic signed [15:0] target_q;
  logic signed [16:0] power_q, mpow_q, spow_q;
  logic signed [24:0] turns_q;
  logic signed [POS_W-1:0] cur_q, base_q;
  logic [POS_W:0]     min_q;
  logic [2:0]         idx_q, best_q;
  logic signed [33:0] turn_q;
  logic signed [27:0] setpoint_q;
  logic               rev_q;

  logic                     in_acc;
  logic                     div_start, div_done;
  logic signed [DIV_NW-1:0] div_num, div_quo;
  logic [DIV_DW-1:0]        div_den;
  logic                     crd_start, crd_done;
  logic signed [CRD_W-1:0]  crd_x;
  logic signed [CRD_ZW-1:0] crd_z;

  logic [14:0]        radius;
  logic signed [31:0] prod_x, prod_y;
  logic signed [37:0] h360;
  logic signed [28:0] turn_in;
  logic               turn_small;
  logic signed [31:0] bp_next, cp_next;
  logic               vec_zero;
  logic signed [CRD_ZW-1:0] ang_r;
  logic signed [15:0] angle16, target_next;
  logic [41:0]        pw_prod;
  logic [17:0]        pw_round;
  logic signed [16:0] pw_sat;
  logic               dead_all;
  logic               restrict_par;
  logic [2:0]         opt_idx;
  logic signed [POS_W-1:0] pick_opt;
  logic signed [POS_W:0]   pick_diff;
  logic [POS_W:0]     pick_d;
  logic               cand_ok;
  logic signed [16:0] s17;

  assign in_acc      = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign cfg_ready_o = 1'b1;

  assign radius     = (rad_q == '0) ? 15'd1 : rad_q;
  assign prod_x     = 32'(stick_twist_i) * 32'(mx_q);
  assign prod_y     = 32'(tw_q) * 32'(my_q);
  assign h360       = 38'(head_q) * 38'sd360;
  assign turn_in    = 29'(heading_position_i) - 29'(setpoint_q);
  assign turn_small = (turn_in < 29'sd16) && (turn_in > -29'sd16);
  assign bp_next    = 32'(sx_q) + $signed(div_quo[31:0]);
  assign cp_next    = 32'(sy_q) - $signed(div_quo[31:0]);
  assign vec_zero   = (bp_q == 32'sd0) && (cp_next == 32'sd0);

  // angle rounded to 1/16 degree, axis cases exact
  assign ang_r = (crd_z + 27'sd2048) >>> 12;
  always_comb begin
    if (bp_q == 32'sd0) begin
      angle16 = (cp_q > 32'sd0) ? 16'sd0 : 16'sd2880;
    end else if (cp_q == 32'sd0) begin
      angle16 = (bp_q > 32'sd0) ? 16'sd1440 : -16'sd1440;
    end else begin
      angle16 = ang_r[15:0];
    end
  end
  assign target_next = -(16'sd2880 + angle16);

  // magnitude gain correction, large x saturates anyway
  assign pw_prod  = 42'(crd_x[25:0]) * 42'd39797;
  assign pw_round = 18'((pw_prod + 42'd8388608) >> 24);
  assign pw_sat   = ((crd_x[CRD_W-1:26] != '0) || (pw_round > 18'd65535)) ?
                    17'sd65535 : $signed(pw_round[16:0]);
  assign dead_all = op_q && in_dead(sx_q, dz_q) && in_dead(sy_q, dz_q) &&
                    in_dead(tw_q, dz_q);

  // setpoint search
  assign restrict_par = prev_q > 16'sd4915;
  assign opt_idx      = (state_q == ST_SET) ? best_q : idx_q;
  assign pick_opt     = base_q + POS_W'(target_q) + POS_W'(opt_off(opt_idx));
  assign pick_diff    = (POS_W+1)'(cur_q) - (POS_W+1)'(pick_opt);
  assign pick_d       = pick_diff[POS_W] ? (POS_W+1)'(-pick_diff) : (POS_W+1)'(pick_diff);
  assign cand_ok      = !restrict_par || (idx_q[0] == rev_q);

  assign s17 = rev_q ? -(17'(spd_q)) : 17'(spd_q);

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!action_i) begin
            div_start = 1'b1;
            div_num   = DIV_NW'(prod_x);
            div_den   = DIV_DW'(radius);
          end else if (!turn_small) begin
            div_start = 1'b1;
            div_num   = DIV_NW'(turn_in) <<< 14;
            div_den   = DEN_ERR;
          end
        end
      end
      ST_DIV_B: begin
        if (div_done) begin
          div_start = 1'b1;
          div_num   = DIV_NW'(prod_y);
          div_den   = DIV_DW'(radius);
        end
      end
      ST_DIV_C: begin
        if (div_done && vec_zero) begin
          div_start = 1'b1;
          div_num   = DIV_NW'(head_q);
          div_den   = DEN_TURNS;
        end
      end
      ST_CORDIC: begin
        if (crd_done) begin
          div_start = 1'b1;
          div_num   = DIV_NW'(head_q);
          div_den   = DEN_TURNS;
        end
      end
      ST_DIV_T: begin
        if (div_done) begin
          div_start = 1'b1;
          div_num   = DIV_NW'(h360);
          div_den   = DEN_CUR;
        end
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign crd_start = (state_q == ST_DIV_C) && div_done && !vec_zero;

  dsm_sdiv u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  dsm_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (crd_start),
    .bp_i    (bp_q),
    .cp_i    (cp_next),
    .done_o  (crd_done),
    .x_o     (crd_x),
    .z_o     (crd_z)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mx_q       <= 16'sd48;
      my_q       <= 16'sd64;
      rad_q      <= 15'd80;
      dz_q       <= 15'd1638;
      setpoint_q <= '0;
      rev_q      <= 1'b0;
      prev_q     <= '0;
      sx_q       <= '0;
      sy_q       <= '0;
      tw_q       <= '0;
      spd_q      <= '0;
      op_q       <= 1'b0;
      act_q      <= 1'b0;
      head_q     <= '0;
      bp_q       <= '0;
      cp_q       <= '0;
      target_q   <= '0;
      power_q    <= '0;
      mpow_q     <= '0;
      spow_q     <= '0;
      turns_q    <= '0;
      cur_q      <= '0;
      base_q     <= '0;
      min_q      <= '0;
      idx_q      <= '0;
      best_q     <= '0;
      turn_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_MODULE_X:   mx_q  <= $signed(cfg_data_i);
          REG_MODULE_Y:   my_q  <= $signed(cfg_data_i);
          REG_MAX_RADIUS: rad_q <= cfg_data_i[14:0];
          REG_DEAD_ZONE:  dz_q  <= cfg_data_i[14:0];
          default:        rad_q <= rad_q;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            act_q  <= action_i;
            sx_q   <= stick_x_i;
            sy_q   <= stick_y_i;
            tw_q   <= stick_twist_i;
            op_q   <= operator_mode_i;
            spd_q  <= drive_speed_i;
            head_q <= heading_position_i;
            if (!action_i) begin
              state_q <= ST_DIV_B;
            end else if (turn_small) begin
              turn_q  <= '0;
              state_q <= ST_MIX;
            end else begin
              state_q <= ST_DRV_DIV;
            end
          end
        end
        ST_DIV_B: begin
          if (div_done) begin
            bp_q    <= bp_next;
            state_q <= ST_DIV_C;
          end
        end
        ST_DIV_C: begin
          if (div_done) begin
            cp_q <= cp_next;
            if (vec_zero) begin
              target_q <= -16'sd2880;
              power_q  <= '0;
              state_q  <= ST_DIV_T;
            end else begin
              state_q <= ST_CORDIC;
            end
          end
        end
        ST_CORDIC: begin
          if (crd_done) begin
            target_q <= target_next;
            power_q  <= dead_all ? 17'sd0 : pw_sat;
            state_q  <= ST_DIV_T;
          end
        end
        ST_DIV_T: begin
          if (div_done) begin
            turns_q <= div_quo[24:0];
            state_q <= ST_DIV_P;
          end
        end
        ST_DIV_P: begin
          if (div_done) begin
            cur_q   <= div_quo[POS_W-1:0];
            base_q  <= POS_W'(turns_q) * 40'sd5760;
            min_q   <= (POS_W+1)'(28800);
            idx_q   <= '0;
            best_q  <= '0;
            state_q <= ST_PICK;
          end
        end
        ST_PICK: begin
          // nearest option wins, first one on ties
          if (cand_ok && (pick_d < min_q)) begin
            min_q  <= pick_d;
            best_q <= idx_q;
          end
          idx_q <= idx_q + 3'd1;
          if (idx_q == 3'd5) begin
            state_q <= ST_SET;
          end
        end
        ST_SET: begin
          setpoint_q <= sat28(pick_opt);
          rev_q      <= best_q[0];
          mpow_q     <= '0;
          spow_q     <= '0;
          state_q    <= ST_OUT;
        end
        ST_DRV_DIV: begin
          if (div_done) begin
            turn_q  <= div_quo[33:0];
            state_q <= ST_MIX;
          end
        end
        ST_MIX: begin
          prev_q  <= spd_q;
          power_q <= '0;
          mpow_q  <= sat17(44'(s17) - 44'(turn_q));
          spow_q  <= sat17(-(44'(s17)) - 44'(turn_q));
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_stall_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign module_power_o   = power_q;
  assign steer_target_o   = setpoint_q;
  assign wheel_reversed_o = rev_q;
  assign master_power_o   = mpow_q;
  assign slave_power_o    = spow_q;

  `include "diff_swerve_module_steer_drive_core_macros.svh"

  `DSM_ASSERT_IMPLY(a_no_accept_when_full, clk_i, rst_ni, out_valid_o, in_stall_o)
  `DSM_ASSERT(a_no_instant_result, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> !out_valid_o)
  `DSM_ASSERT_IMPLY(a_steer_no_mix, clk_i, rst_ni, out_valid_o && !act_q, master_power_o == 17'sd0 && slave_power_o == 17'sd0)
  `DSM_ASSERT_IMPLY(a_drive_no_power, clk_i, rst_ni, out_valid_o && act_q, module_power_o == 17'sd0)

endmodule

/* rtl/core/dsm_sdiv.sv */
// ----------------------------------------------------------------------------
// dsm_sdiv
// Bit-serial signed divider, truncating toward zero, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module dsm_sdiv (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [dsm_pkg::DIV_NW-1:0]   num_i,
  input  logic        [dsm_pkg::DIV_DW-1:0]   den_i,
  output logic                                done_o,
  output logic signed [dsm_pkg::DIV_NW-1:0]   quo_o
);
  import dsm_pkg::*;

  localparam int unsigned CW = $clog2(DIV_NW);

  logic              busy_q;
  logic              done_q;
  logic              neg_q;
  logic [CW-1:0]     cnt_q;
  logic [DIV_DW-1:0] rem_q;
  logic [DIV_DW-1:0] den_q;
  logic [DIV_NW-1:0] sh_q;
  logic [DIV_DW:0]   trial;
  logic              fits;

  assign trial = {rem_q, sh_q[DIV_NW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      sh_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        den_q  <= den_i;
        neg_q  <= num_i[DIV_NW-1];
        sh_q   <= num_i[DIV_NW-1] ? DIV_NW'(-num_i) : DIV_NW'(num_i);
      end else if (busy_q) begin
        // dividend bits leave at the top, quotient bits enter at the bottom
        rem_q <= fits ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
        sh_q  <= {sh_q[DIV_NW-2:0], fits};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DIV_NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(sh_q) : $signed(sh_q);

endmodule

/* rtl/core/dsm_cordic.sv */
// ----------------------------------------------------------------------------
// dsm_cordic
// Iterative vectoring cordic: atan2 in 2^-16 degree and scaled magnitude.
// ----------------------------------------------------------------------------
module dsm_cordic #(
  parameter int unsigned STEPS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [31:0]                 bp_i,
  input  logic signed [31:0]                 cp_i,
  output logic                               done_o,
  output logic signed [dsm_pkg::CRD_W-1:0]   x_o,
  output logic signed [dsm_pkg::CRD_ZW-1:0]  z_o
);
  import dsm_pkg::*;

  localparam int unsigned IW = $clog2(STEPS);

  logic                     busy_q;
  logic                     done_q;
  logic [IW-1:0]            cnt_q;
  logic signed [CRD_W-1:0]  x_q;
  logic signed [CRD_W-1:0]  y_q;
  logic signed [CRD_ZW-1:0] z_q;
  logic signed [CRD_W-1:0]  cp_ext;
  logic signed [CRD_W-1:0]  bp_ext;
  logic [4:0]               shamt;
  logic signed [CRD_W-1:0]  x_sh;
  logic signed [CRD_W-1:0]  y_sh;
  logic signed [CRD_ZW-1:0] step_ang;

  assign cp_ext   = CRD_W'(cp_i);
  assign bp_ext   = CRD_W'(bp_i);
  assign shamt    = 5'(cnt_q);
  assign x_sh     = x_q >>> shamt;
  assign y_sh     = y_q >>> shamt;
  assign step_ang = $signed(CRD_ZW'(atan_entry(shamt)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        // left half plane folds over with a half turn preloaded
        if (cp_i < 0) begin
          x_q <= (-cp_ext) <<< 8;
          y_q <= (-bp_ext) <<< 8;
          z_q <= (bp_i >= 0) ? Z_HALF_TURN : -Z_HALF_TURN;
        end else begin
          x_q <= cp_ext <<< 8;
          y_q <= bp_ext <<< 8;
          z_q <= '0;
        end
      end else if (busy_q) begin
        if (y_q >= 0) begin
          x_q <= x_q + y_sh;
          y_q <= y_q - x_sh;
          z_q <= z_q + step_ang;
        end else begin
          x_q <= x_q - y_sh;
          y_q <= y_q + x_sh;
          z_q <= z_q - step_ang;
        end
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == IW'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign z_o    = z_q;

endmodule

/* verif/swerve_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swerve_checker
// Watches the config, input and result channels of the swerve module core,
// predicts each result from a private copy of the module state, and counts
// field mismatches, unexpected results and results still owed.
// ----------------------------------------------------------------------------
module swerve_checker #(
  parameter int unsigned COUNTS_PER_TURN = 360,
  parameter int unsigned CORDIC_STEPS    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               action_i,
  input  logic signed [15:0] stick_x_i,
  input  logic signed [15:0] stick_y_i,
  input  logic signed [15:0] stick_twist_i,
  input  logic               operator_mode_i,
  input  logic signed [15:0] drive_speed_i,
  input  logic signed [27:0] heading_position_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [16:0] module_power_i,
  input  logic signed [27:0] steer_target_i,
  input  logic               wheel_reversed_i,
  input  logic signed [16:0] master_power_i,
  input  logic signed [16:0] slave_power_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 results_seen_o
);
  import dsm_pkg::*;

  typedef struct packed {
    logic signed [16:0] power;
    logic signed [27:0] target;
    logic               reversed;
    logic signed [16:0] master;
    logic signed [16:0] slave;
  } wheel_result_t;

  wheel_result_t expected_q[$];

  longint pos_x, pos_y, radius, dz;
  longint setpoint, last_speed;
  bit     reversed_flag;

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint atan_step(int i);
    longint t[24] = '{2949120, 1740967, 919879, 466945, 234378, 117304, 58666,
                      29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                      29, 14, 7, 4, 2, 1, 0};
    return t[i];
  endfunction

  function automatic void pick_setpoint(longint heading, longint tgt);
    longint turns, cur, base, opt, d, best_move;
    int first, incr, best;
    turns = heading / (16 * longint'(COUNTS_PER_TURN));
    cur = heading * 360 / longint'(COUNTS_PER_TURN);
    base = turns * 5760;
    first = 0;
    incr = 1;
    best = 0;
    best_move = 28800;
    if (last_speed > 4915) begin
      incr = 2;
      if (reversed_flag) first = 1;
    end
    for (int i = first; i < 6; i += incr) begin
      opt = base + tgt + longint'(i - 2) * 2880;
      d = absl(cur - opt);
      if (d < best_move) begin
        best_move = d;
        best = i;
      end
    end
    setpoint = clamp(base + tgt + longint'(best - 2) * 2880, -134217728, 134217727);
    reversed_flag = best[0];
  endfunction

  function automatic wheel_result_t predict_wheel();
    wheel_result_t r;
    longint sx, sy, tw, spd, hd, pw, mp, sp, rr, bp, cp, tgt, x, y, z, nx, ang;
    longint turn, s;
    sx = stick_x_i;
    sy = stick_y_i;
    tw = stick_twist_i;
    spd = drive_speed_i;
    hd = heading_position_i;
    pw = 0;
    mp = 0;
    sp = 0;
    if (!action_i) begin
      rr = radius == 0 ? 1 : radius;
      bp = sx + tw * pos_x / rr;
      cp = sy - tw * pos_y / rr;
      tgt = -2880;
      if (bp != 0 || cp != 0) begin
        x = cp;
        y = bp;
        z = 0;
        if (x < 0) begin
          x = -x;
          y = -y;
          z = bp >= 0 ? 180 * 65536 : -180 * 65536;
        end
        x *= 256;
        y *= 256;
        for (int i = 0; i < int'(CORDIC_STEPS) && i < 24; i++) begin
          if (y >= 0) begin
            nx = x + fshr(y, i);
            y = y - fshr(x, i);
            z += atan_step(i);
          end else begin
            nx = x - fshr(y, i);
            y = y + fshr(x, i);
            z -= atan_step(i);
          end
          x = nx;
        end
        pw = (x * 39797 + (longint'(1) << 23)) >>> 24;
        ang = fshr(z + 2048, 12);
        if (bp == 0) ang = cp > 0 ? 0 : 2880;
        else if (cp == 0) ang = bp > 0 ? 1440 : -1440;
        tgt = -(2880 + ang);
      end
      pick_setpoint(hd, tgt);
      if (operator_mode_i && absl(sx) <= dz && absl(sy) <= dz && absl(tw) <= dz) pw = 0;
      pw = clamp(pw, -65536, 65535);
    end else begin
      turn = hd - setpoint;
      last_speed = spd;
      if (absl(turn) < 16) turn = 0;
      else turn = turn * 16384 / 2880;
      s = reversed_flag ? -spd : spd;
      mp = clamp(s - turn, -65536, 65535);
      sp = clamp(-s - turn, -65536, 65535);
    end
    r.power = pw[16:0];
    r.target = setpoint[27:0];
    r.reversed = reversed_flag;
    r.master = mp[16:0];
    r.slave = sp[16:0];
    return r;
  endfunction

  task automatic compare_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    wheel_result_t e;
    if (!rst_ni) begin
      pos_x = 48;
      pos_y = 64;
      radius = 80;
      dz = 1638;
      setpoint = 0;
      reversed_flag = 0;
      last_speed = 0;
      expected_q.delete();
      fail_count_o = 0;
      results_seen_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_MODULE_X:   pos_x = longint'(signed'(cfg_data_i));
          REG_MODULE_Y:   pos_y = longint'(signed'(cfg_data_i));
          REG_MAX_RADIUS: radius = cfg_data_i[14:0];
          REG_DEAD_ZONE:  dz = cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        results_seen_o++;
        if (expected_q.size() == 0) begin
          $display("%0t: result with none expected, actual power %0d target %0d",
                   $time, module_power_i, steer_target_i);
          fail_count_o++;
        end else begin
          e = expected_q.pop_front();
          compare_field("module_power", e.power, module_power_i);
          compare_field("steer_target", e.target, steer_target_i);
          compare_field("wheel_reversed", e.reversed, wheel_reversed_i);
          compare_field("master_power", e.master, master_power_i);
          compare_field("slave_power", e.slave, slave_power_i);
        end
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(predict_wheel());
      pending_o = expected_q.size();
    end
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives steer and drive items into the swerve module core over several
// geometry and deadzone settings, with random gaps and stalls on both sides;
// a checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import dsm_pkg::*;

  localparam longint CycleLimit = 2000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [15:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               action_i = 1'b0;
  logic signed [15:0] stick_x_i = '0;
  logic signed [15:0] stick_y_i = '0;
  logic signed [15:0] stick_twist_i = '0;
  logic               operator_mode_i = 1'b0;
  logic signed [15:0] drive_speed_i = '0;
  logic signed [27:0] heading_position_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [16:0] module_power_o;
  logic signed [27:0] steer_target_o;
  logic               wheel_reversed_o;
  logic signed [16:0] master_power_o;
  logic signed [16:0] slave_power_o;
  int                 fail_count, pending, results_seen;
  longint             cycle_count = 0;
  bit                 hold_off = 1'b0;
  int                 steer_items = 0, drive_items = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  diff_swerve_module_steer_drive_core dut (.*);

  swerve_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .action_i, .stick_x_i, .stick_y_i,
    .stick_twist_i, .operator_mode_i, .drive_speed_i, .heading_position_i,
    .out_valid_i(out_valid_o), .out_stall_i, .module_power_i(module_power_o),
    .steer_target_i(steer_target_o), .wheel_reversed_i(wheel_reversed_o),
    .master_power_i(master_power_o), .slave_power_i(slave_power_o),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver stalls: drawn at random each cycle, mostly short, plus a forced long hold-off
  always @(posedge clk_i) begin
    int r;
    r = $urandom_range(0, 99);
    if (hold_off) out_stall_i <= 1'b1;
    else if (r < 40) out_stall_i <= 1'b0;
    else if (r < 97) out_stall_i <= r[0];
    else out_stall_i <= 1'b1;
  end

  function automatic logic signed [15:0] rand_stick();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sd16384;
    if (r == 1) return -16'sd16384;
    if (r == 2) return 16'(int'($urandom_range(0, 4000)) - 2000);
    if (r == 3) return 16'($urandom);
    return 16'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 9) < 8 ? $urandom_range(0, 3) : $urandom_range(10, 120);
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_wheel(logic act, logic signed [15:0] sx, logic signed [15:0] sy,
                            logic signed [15:0] tw, logic op, logic signed [15:0] spd,
                            logic signed [27:0] hd);
    in_valid_i <= 1'b1;
    action_i <= act;
    stick_x_i <= sx;
    stick_y_i <= sy;
    stick_twist_i <= tw;
    operator_mode_i <= op;
    drive_speed_i <= spd;
    heading_position_i <= hd;
    do @(posedge clk_i); while (in_stall_o);
    if (act) drive_items++;
    else steer_items++;
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    drop_valid();
    do @(posedge clk_i); while (pending != 0);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_wheel();
    logic signed [27:0] hd;
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) hd = 28'(int'($urandom_range(0, 40000)) - 20000);
    else if (r < 8) hd = 28'($urandom);
    else hd = r[0] ? 28'sh7ffffff : 28'sh8000000;
    send_wheel($urandom_range(0, 2) == 0, rand_stick(), rand_stick(), rand_stick(),
               1'($urandom), $urandom_range(0, 3) == 0 ? rand_stick()
               : 16'(int'($urandom_range(4000, 16384)) * ($urandom_range(0, 1) ? 1 : -1)),
               hd);
    if ($urandom_range(0, 2) == 0) begin
      drop_valid();
      idle_gap();
    end
  endtask

  initial begin
    logic [15:0] settings [4][4];
    settings = '{'{16'd48, 16'd64, 16'd80, 16'd1638},
                 '{16'h7fff, 16'h8000, 16'd1, 16'd0},
                 '{16'h8000, 16'h7fff, 16'h7fff, 16'd16384},
                 '{16'hffe0, 16'd20, 16'd0, 16'd500}};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, axes, zero vector, deadzone, parity lock, turn edges
    send_wheel(1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 28'sd0);
    send_wheel(1'b0, 16'sd16384, 16'sd0, 16'sd0, 1'b0, 16'sd0, 28'sd100);
    send_wheel(1'b0, -16'sd16384, 16'sd0, 16'sd0, 1'b0, 16'sd0, -28'sd100);
    send_wheel(1'b0, 16'sd0, 16'sd16384, 16'sd0, 1'b0, 16'sd0, 28'sd5760);
    send_wheel(1'b0, 16'sd0, -16'sd16384, 16'sd0, 1'b0, 16'sd0, -28'sd5761);
    send_wheel(1'b0, 16'sd100, 16'sd100, 16'sd100, 1'b1, 16'sd0, 28'sd3000);
    send_wheel(1'b0, 16'sd16384, 16'sd16384, 16'sd16384, 1'b0, 16'sd0, 28'sh7ffffff);
    send_wheel(1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd16384, 28'sh7ffffff);
    send_wheel(1'b0, -16'sd16384, -16'sd16384, -16'sd16384, 1'b0, 16'sd0, 28'sh8000000);
    send_wheel(1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b0, -16'sd16384, 28'sh8000000);
    send_wheel(1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd4916, 28'sd0);
    send_wheel(1'b0, 16'sd3000, -16'sd5000, 16'sd0, 1'b0, 16'sd0, 28'sd1000);
    send_wheel(1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd4915, 28'sd0);
    send_wheel(1'b0, -16'sd3000, 16'sd5000, 16'sd0, 1'b0, 16'sd0, 28'sd1000);
    send_wheel(1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'h8000, 28'sd15);
    send_wheel(1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'h7fff, -28'sd16);
    send_wheel(1'b0, 16'hffff, 16'h7fff, 16'h8000, 1'b1, 16'hffff, 28'hfffffff);
    drain();
    // pressure: stall the result side while items keep coming
    hold_off <= 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_off <= 1'b0;
      end
      repeat (6) random_wheel();
    join
    drain();
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_MODULE_X, settings[p][0]);
      write_reg(REG_MODULE_Y, settings[p][1]);
      write_reg(REG_MAX_RADIUS, settings[p][2]);
      write_reg(REG_DEAD_ZONE, settings[p][3]);
      repeat (270) random_wheel();
      drain();
    end
    $display("covered %0d steer and %0d drive items, %0d results, four register settings",
             steer_items, drive_items, results_seen);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
